/* hdl/tlbfl_pkg.sv */
// Package: sizes, operation and mode codes, and request/response types for the TLB.
package tlbfl_pkg;

  localparam int ENTRIES    = 16;
  localparam int PAGE_BITS  = 8;
  localparam int FRAME_BITS = 8;
  localparam int IDX_W      = $clog2(ENTRIES);
  localparam int PTR_W      = $clog2(ENTRIES + 1);
  localparam int RANK_W     = IDX_W;

  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_UPDATE = 1'b1;

  localparam logic MODE_FIFO = 1'b0;
  localparam logic MODE_LRU  = 1'b1;

  typedef logic [PAGE_BITS-1:0]  page_t;
  typedef logic [FRAME_BITS-1:0] frame_t;
  typedef logic [IDX_W-1:0]      idx_t;
  typedef logic [PTR_W-1:0]      ptr_t;
  typedef logic [RANK_W-1:0]     rank_t;

  typedef struct packed {
    logic   op;
    page_t  page;
    frame_t frame;
  } req_t;

  typedef struct packed {
    logic   hit;
    frame_t frame;
  } rsp_t;

endpackage

/* hdl/tlbfl_ifs.sv */
// Interfaces: lookup/update request channel, result channel and mode write channel.
interface tlbfl_in_if;
  logic                   valid;
  logic                   ready;
  logic                   op;
  tlbfl_pkg::page_t       page_number;
  tlbfl_pkg::frame_t      frame_number;

  modport source (output valid, op, page_number, frame_number, input ready);
  modport sink   (input valid, op, page_number, frame_number, output ready);
endinterface

interface tlbfl_out_if;
  logic                   valid;
  logic                   ready;
  logic                   hit;
  tlbfl_pkg::frame_t      frame_out;

  modport source (output valid, hit, frame_out, input ready);
  modport sink   (input valid, hit, frame_out, output ready);
endinterface

interface tlbfl_cfg_if;
  logic                   valid;
  logic                   ready;
  logic                   replace_mode;

  modport source (output valid, replace_mode, input ready);
  modport sink   (input valid, replace_mode, output ready);
endinterface

/* hdl/tlbfl_array.sv */
// Entry store: parallel page compare, recency ranks, fill pointer and replacement.
module tlbfl_array (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              req_go,
  input  tlbfl_pkg::req_t   req,
  input  logic              mode,
  output tlbfl_pkg::rsp_t   rsp
);
  import tlbfl_pkg::*;

  logic [ENTRIES-1:0] valid_r, valid_nxt;
  page_t              page_r  [ENTRIES];
  frame_t             frame_r [ENTRIES];
  rank_t              rank_r  [ENTRIES];
  ptr_t               fill_ptr_r, fill_ptr_nxt;

  logic [ENTRIES-1:0] match;
  logic               hit;
  idx_t               hit_idx;
  logic               free_any;
  idx_t               free_idx;
  idx_t               victim_idx;
  idx_t               fifo_idx;
  idx_t               slot;
  logic               do_write;
  logic               do_touch;
  ptr_t               old_rank;

  // Parallel tag compare, lowest index wins
  always_comb begin
    hit_idx    = '0;
    free_idx   = '0;
    victim_idx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      match[i] = valid_r[i] && (page_r[i] == req.page);
      if (match[i]) begin
        hit_idx = IDX_W'(i);
      end
      if (!valid_r[i]) begin
        free_idx = IDX_W'(i);
      end
      // ranks form a permutation when full, so the oldest is unique
      if (rank_r[i] == RANK_W'(ENTRIES - 1)) begin
        victim_idx = IDX_W'(i);
      end
    end
    hit      = |match;
    free_any = ~&valid_r;
  end

  assign rsp.hit   = hit;
  assign rsp.frame = hit ? frame_r[hit_idx] : '0;

  assign fifo_idx = (fill_ptr_r >= PTR_W'(ENTRIES)) ? '0 : fill_ptr_r[IDX_W-1:0];

  // Choose the slot and what happens to it
  always_comb begin
    slot         = fifo_idx;
    do_write     = 1'b0;
    do_touch     = 1'b0;
    fill_ptr_nxt = fill_ptr_r;
    if (req_go && req.op == OP_UPDATE) begin
      unique case (mode)
        MODE_FIFO: begin
          slot         = fifo_idx;
          do_write     = 1'b1;
          do_touch     = 1'b1;
          fill_ptr_nxt = PTR_W'(fifo_idx) + PTR_W'(1);
        end
        MODE_LRU: begin
          priority if (hit) begin
            slot     = hit_idx;
            do_touch = 1'b1;
          end else if (free_any) begin
            slot         = free_idx;
            do_write     = 1'b1;
            do_touch     = 1'b1;
            fill_ptr_nxt = PTR_W'(free_idx) + PTR_W'(1);
          end else begin
            slot     = victim_idx;
            do_write = 1'b1;
            do_touch = 1'b1;
          end
        end
        default: begin
          do_write = 1'b0;
        end
      endcase
    end
  end

  assign old_rank = valid_r[slot] ? PTR_W'(rank_r[slot]) : PTR_W'(ENTRIES);

  always_comb begin
    valid_nxt = valid_r;
    if (do_write) begin
      valid_nxt[slot] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      fill_ptr_r <= '0;
    end else begin
      valid_r    <= valid_nxt;
      fill_ptr_r <= fill_ptr_nxt;
    end
  end

  // Promote the touched slot; age every entry that was more recent
  always_ff @(posedge clk) begin
    for (int i = 0; i < ENTRIES; i++) begin
      if (do_touch) begin
        if (IDX_W'(i) == slot) begin
          rank_r[i] <= '0;
        end else if (valid_r[i] && (PTR_W'(rank_r[i]) < old_rank)) begin
          rank_r[i] <= rank_r[i] + RANK_W'(1);
        end
      end
      if (do_write && IDX_W'(i) == slot) begin
        page_r[i]  <= req.page;
        frame_r[i] <= req.frame;
      end
    end
  end

endmodule

/* hdl/tlb_lookup_fifo_lru.sv */
// Top level: request register, entry store and result register of the TLB.
// A request is captured in the request register and its result in the result
// register, which offers it; a result not taken holds back the next request.
// One request per cycle is accepted while results are taken; the single-stage
// compare and update against the entry flip-flops sets this figure.
// Reset clears every valid bit, the fill pointer and both channel stages,
// and selects first-in first-out replacement.
module tlb_lookup_fifo_lru (
  input  logic  clk,
  input  logic  rst_n,
  tlbfl_in_if.sink    in_if,
  tlbfl_out_if.source out_if,
  tlbfl_cfg_if.sink   cfg_if
);
  import tlbfl_pkg::*;

  logic   req_valid_r;
  req_t   req_r;
  logic   mode_r;
  logic   out_valid_r;
  rsp_t   out_r;
  rsp_t   rsp;
  logic   advance;

  assign advance     = req_valid_r && (!out_valid_r || out_if.ready);
  assign in_if.ready = !req_valid_r || advance;
  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      mode_r      <= MODE_FIFO;
    end else begin
      if (in_if.ready) begin
        req_valid_r <= in_if.valid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_if.valid) begin
        mode_r <= cfg_if.replace_mode;
      end
    end
  end

  // Payload holds without reset
  always_ff @(posedge clk) begin
    if (in_if.ready && in_if.valid) begin
      req_r.op    <= in_if.op;
      req_r.page  <= in_if.page_number;
      req_r.frame <= in_if.frame_number;
    end
    if (advance) begin
      out_r <= rsp;
    end
  end

  tlbfl_array u_array (
    .clk    (clk),
    .rst_n  (rst_n),
    .req_go (advance),
    .req    (req_r),
    .mode   (mode_r),
    .rsp    (rsp)
  );

  assign out_if.valid     = out_valid_r;
  assign out_if.hit       = out_r.hit;
  assign out_if.frame_out = out_r.frame;

endmodule
